// ===== rtl/ptrs_pkg.sv =====
package ptrs_pkg;

	localparam int MAX_SLOTS = 8;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_CREATE  = 2'd1;
	localparam logic [1:0] OP_SUSPEND = 2'd2;
	localparam logic [1:0] OP_RESUME  = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  task_req;
		logic [15:0] period;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  task_index;
		logic [15:0] tick_count;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  slot;
		logic [15:0] period;
	} cmd_t;

endpackage

// ===== rtl/periodic_task_release_scheduler_top.sv =====
// Periodic task release scheduler.
// Input channel (push/full, item): tick, create, suspend and resume beats.
// A beat is taken when push is high and full is low; a two-entry command
// queue sits in front of the executing back end.
// Result channel (empty/pop, result): one beat per task released on a tick,
// lowest slot first, last set on the final beat of that tick. The head beat
// is presented while empty is low and taken when pop is high.
// Create, suspend and resume give no result.
// A tick walks the slots one after another: an idle or suspended slot only
// passes the check and advance states, while an active created slot also
// waits on the 16-step serial remainder unit.
// A release is held until the next hit or the end of the walk, so the first
// result of a tick can trail its hit by the rest of the walk.
// Reset clears the tick counter and all periods and marks every slot active.
// If the result queue fills, the slot walk pauses until pop frees space;
// the command queue then fills and full holds off further beats.
module periodic_task_release_scheduler_top #(
	parameter int TASK_COUNT = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  ptrs_pkg::in_item_t  item,
	output logic                empty,
	input  logic                pop,
	output ptrs_pkg::out_item_t result
);

	localparam int SLOTS = (TASK_COUNT < ptrs_pkg::MAX_SLOTS) ? TASK_COUNT
		: ptrs_pkg::MAX_SLOTS;

	ptrs_pkg::cmd_t      cmd_in;
	ptrs_pkg::cmd_t      cmd_out;
	logic                cmd_push;
	logic                cmd_pop;
	logic                cmd_empty;
	ptrs_pkg::out_item_t res;
	logic                res_push;
	logic                res_full;

	ptrs_front #(.SLOTS(SLOTS)) u_front (
		.item     (item),
		.push     (push),
		.full     (full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	ptrs_fifo #(.T(ptrs_pkg::cmd_t), .DEPTH(2)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.full   (full),
		.din    (cmd_in),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.dout   (cmd_out)
	);

	ptrs_back #(.SLOTS(SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	ptrs_fifo #(.T(ptrs_pkg::out_item_t), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.din    (res),
		.pop    (pop),
		.empty  (empty),
		.dout   (result)
	);

endmodule

// ===== rtl/ptrs_fifo.sv =====
module ptrs_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  T     din,
	input  logic pop,
	output logic empty,
	output T     dout
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ptrs_front.sv =====
module ptrs_front #(
	parameter int SLOTS = 8
) (
	input  ptrs_pkg::in_item_t item,
	input  logic               push,
	input  logic               full,
	output logic               cmd_push,
	output ptrs_pkg::cmd_t     cmd
);

	logic keep;

	// slot commands beyond the table are dropped here
	always_comb begin
		keep = (item.op == ptrs_pkg::OP_TICK) || (32'(item.task_req) < SLOTS);
		cmd.op     = item.op;
		cmd.slot   = item.task_req;
		cmd.period = item.period;
	end

	assign cmd_push = push && !full && keep;

endmodule

// ===== rtl/ptrs_mod.sv =====
module ptrs_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [15:0] divisor,
	output logic        done,
	output logic        rem_zero
);

	logic [15:0] dvd_q;
	logic [15:0] dsr_q;
	logic [15:0] rem_q;
	logic [3:0]  bit_q;
	logic        run_q;
	logic        done_q;
	logic [16:0] sh;
	logic        ge;
	logic [15:0] rem_nxt;

	always_comb begin
		sh      = {rem_q, dvd_q[15]};
		ge      = (sh >= {1'b0, dsr_q});
		rem_nxt = ge ? 16'(sh - {1'b0, dsr_q}) : sh[15:0];
	end

	assign done     = done_q;
	assign rem_zero = (rem_q == '0);

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[14:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				bit_q <= '0;
			end else if (run_q) begin
				bit_q <= bit_q + 1'b1;
				if (bit_q == 4'd15) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/ptrs_back.sv =====
module ptrs_back #(
	parameter int SLOTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_empty,
	input  ptrs_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	input  logic                res_full,
	output logic                res_push,
	output ptrs_pkg::out_item_t res
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_ADV   = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0]    state_q;
	logic [15:0]   cnt_q;
	logic [15:0]   period_q [SLOTS];
	logic          active_q [SLOTS];
	logic [IW-1:0] idx_q;
	logic          hit_q;
	logic          hold_vld_q;
	logic [IW-1:0] hold_idx_q;
	logic [IW-1:0] cmd_slot;
	logic          eligible;
	logic          mod_start;
	logic          mod_done;
	logic          mod_zero;
	logic          at_end;

	assign cmd_slot  = cmd.slot[IW-1:0];
	assign eligible  = (period_q[idx_q] != '0) && active_q[idx_q];
	assign mod_start = (state_q == S_CHECK) && eligible;
	assign at_end    = (idx_q == IW'(SLOTS - 1));
	assign cmd_pop   = (state_q == S_IDLE) && !cmd_empty;

	ptrs_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (cnt_q),
		.divisor  (period_q[idx_q]),
		.done     (mod_done),
		.rem_zero (mod_zero)
	);

	always_comb begin
		res_push       = 1'b0;
		res.task_index = 3'(hold_idx_q);
		res.tick_count = cnt_q;
		res.last       = (state_q == S_FLUSH);
		if (!res_full && hold_vld_q) begin
			if (state_q == S_ADV && hit_q) begin
				res_push = 1'b1;
			end else if (state_q == S_FLUSH) begin
				res_push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			hold_vld_q <= 1'b0;
			hold_idx_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				period_q[i] <= '0;
				active_q[i] <= 1'b1;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						unique case (cmd.op)
							ptrs_pkg::OP_TICK: begin
								cnt_q      <= cnt_q + 1'b1;
								idx_q      <= '0;
								hold_vld_q <= 1'b0;
								state_q    <= S_CHECK;
							end
							ptrs_pkg::OP_CREATE:  period_q[cmd_slot] <= cmd.period;
							ptrs_pkg::OP_SUSPEND: active_q[cmd_slot] <= 1'b0;
							ptrs_pkg::OP_RESUME:  active_q[cmd_slot] <= 1'b1;
							default: ;
						endcase
					end
				end
				S_CHECK: begin
					if (eligible) begin
						state_q <= S_MOD;
					end else begin
						hit_q   <= 1'b0;
						state_q <= S_ADV;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						hit_q   <= mod_zero;
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					// a new hit pushes the held one out as not-last
					if (!(hit_q && hold_vld_q && res_full)) begin
						if (hit_q) begin
							hold_vld_q <= 1'b1;
							hold_idx_q <= idx_q;
						end
						if (at_end) begin
							state_q <= S_FLUSH;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_CHECK;
						end
					end
				end
				S_FLUSH: begin
					if (!hold_vld_q || !res_full) begin
						hold_vld_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== bench/periodic_task_release_scheduler_top_tb.sv =====
module periodic_task_release_scheduler_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TASK_COUNT   = 8;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 200;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	ptrs_pkg::in_item_t  item;
	logic                empty;
	logic                pop;
	ptrs_pkg::out_item_t result;

	periodic_task_release_scheduler_top #(
		.TASK_COUNT(TASK_COUNT)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// scheduler shadow state
	logic [15:0]         sched_count;
	logic [15:0]         sched_period [TASK_COUNT];
	logic                sched_active [TASK_COUNT];
	ptrs_pkg::out_item_t release_q [$];

	int fail_count;
	int beats_sent;
	int ticks_sent;
	int releases_seen;
	bit gaps_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic ptrs_pkg::in_item_t beat_of(input logic [1:0] op, input int slot,
		input int per);
		ptrs_pkg::in_item_t b;
		b.op       = op;
		b.task_req = 3'(slot);
		b.period   = 16'(per);
		return b;
	endfunction

	task automatic predict_release(input ptrs_pkg::in_item_t b);
		ptrs_pkg::out_item_t r;
		int                  last_hit;
		last_hit = -1;
		if (b.op == ptrs_pkg::OP_TICK) begin
			sched_count = sched_count + 16'd1;
			ticks_sent++;
			for (int s = 0; s < TASK_COUNT; s++) begin
				if (sched_period[s] != 16'd0 && sched_active[s] &&
				    (sched_count % sched_period[s]) == 16'd0)
					last_hit = s;
			end
			for (int s = 0; s < TASK_COUNT; s++) begin
				if (sched_period[s] != 16'd0 && sched_active[s] &&
				    (sched_count % sched_period[s]) == 16'd0) begin
					r.task_index = 3'(s);
					r.tick_count = sched_count;
					r.last       = (s == last_hit);
					release_q.push_back(r);
				end
			end
		end else if (int'(b.task_req) < TASK_COUNT) begin
			case (b.op)
				ptrs_pkg::OP_CREATE:  sched_period[b.task_req] = b.period;
				ptrs_pkg::OP_SUSPEND: sched_active[b.task_req] = 1'b0;
				ptrs_pkg::OP_RESUME:  sched_active[b.task_req] = 1'b1;
				default: ;
			endcase
		end
	endtask

	task automatic send_beat(input ptrs_pkg::in_item_t b);
		push <= 1'b1;
		item <= b;
		do @(posedge clk); while (full);
		predict_release(b);
		beats_sent++;
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic test_idle_ticks();
		send_beat(beat_of(ptrs_pkg::OP_TICK, 0, 0));
		send_beat(beat_of(ptrs_pkg::OP_TICK, 5, 16'hFFFF));
	endtask

	task automatic test_period_extremes();
		send_beat(beat_of(ptrs_pkg::OP_CREATE, 0, 1));
		send_beat(beat_of(ptrs_pkg::OP_CREATE, 7, 16'hFFFF));
		send_beat(beat_of(ptrs_pkg::OP_CREATE, 3, 5));
		send_beat(beat_of(ptrs_pkg::OP_CREATE, 3, 0));
		send_beat(beat_of(ptrs_pkg::OP_TICK, 0, 0));
		send_beat(beat_of(ptrs_pkg::OP_TICK, 7, 16'hAAAA));
	endtask

	task automatic test_all_slots();
		for (int s = 1; s < TASK_COUNT; s++)
			send_beat(beat_of(ptrs_pkg::OP_CREATE, s, 1));
		send_beat(beat_of(ptrs_pkg::OP_TICK, 0, 0));
	endtask

	task automatic test_suspend_resume();
		send_beat(beat_of(ptrs_pkg::OP_SUSPEND, 0, 0));
		send_beat(beat_of(ptrs_pkg::OP_SUSPEND, 7, 0));
		// period changes, slot stays suspended
		send_beat(beat_of(ptrs_pkg::OP_CREATE, 0, 2));
		send_beat(beat_of(ptrs_pkg::OP_TICK, 0, 0));
		send_beat(beat_of(ptrs_pkg::OP_RESUME, 0, 0));
		send_beat(beat_of(ptrs_pkg::OP_TICK, 0, 0));
	endtask

	task automatic test_random(input int n);
		int r;
		int sel;
		int per;
		for (int i = 0; i < n; i++) begin
			gaps_on = (i < n - 40) && ((i / 60) % 2 == 0 || i % 60 >= 20);
			r = $urandom_range(0, 99);
			if (r < 50) begin
				send_beat(beat_of(ptrs_pkg::OP_TICK, $urandom_range(0, 7),
					$urandom_range(0, 65535)));
			end else if (r < 75) begin
				sel = $urandom_range(0, 9);
				if (sel == 0)
					per = 0;
				else if (sel == 1)
					per = $urandom_range(0, 65535);
				else if (sel == 2)
					per = 16'hFFFF;
				else
					per = $urandom_range(1, 12);
				send_beat(beat_of(ptrs_pkg::OP_CREATE, $urandom_range(0, 7), per));
			end else if (r < 88) begin
				send_beat(beat_of(ptrs_pkg::OP_SUSPEND, $urandom_range(0, 7),
					$urandom_range(0, 65535)));
			end else begin
				send_beat(beat_of(ptrs_pkg::OP_RESUME, $urandom_range(0, 7),
					$urandom_range(0, 65535)));
			end
		end
	endtask

	task automatic test_back_to_back();
		gaps_on = 0;
		send_beat(beat_of(ptrs_pkg::OP_CREATE, 0, 3));
		send_beat(beat_of(ptrs_pkg::OP_CREATE, 1, 16'hFFFF));
		send_beat(beat_of(ptrs_pkg::OP_CREATE, 2, 7));
		send_beat(beat_of(ptrs_pkg::OP_CREATE, 3, 1));
		send_beat(beat_of(ptrs_pkg::OP_CREATE, 4, 2));
		send_beat(beat_of(ptrs_pkg::OP_SUSPEND, 4, 0));
		send_beat(beat_of(ptrs_pkg::OP_RESUME, 6, 0));
		send_beat(beat_of(ptrs_pkg::OP_CREATE, 6, 16));
		send_beat(beat_of(ptrs_pkg::OP_TICK, 0, 0));
		send_beat(beat_of(ptrs_pkg::OP_TICK, 0, 0));
		send_beat(beat_of(ptrs_pkg::OP_TICK, 0, 0));
		send_beat(beat_of(ptrs_pkg::OP_TICK, 0, 0));
	endtask

	// result side: random pop stalls, compare against oldest expected beat
	initial begin
		int                  stall;
		ptrs_pkg::out_item_t want;
		stall = 0;
		pop <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				releases_seen++;
				if (release_q.size() == 0) begin
					$error("unexpected release beat: task_index %0d tick_count %0d last %0d",
					       result.task_index, result.tick_count, result.last);
					fail_count++;
				end else begin
					want = release_q.pop_front();
					if (result.task_index !== want.task_index) begin
						$error("task_index mismatch: expected %0d, got %0d",
						       want.task_index, result.task_index);
						fail_count++;
					end
					if (result.tick_count !== want.tick_count) begin
						$error("tick_count mismatch: expected %0d, got %0d",
						       want.tick_count, result.tick_count);
						fail_count++;
					end
					if (result.last !== want.last) begin
						$error("last mismatch: expected %0d, got %0d", want.last, result.last);
						fail_count++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				pop <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 16) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no beat moved for %0d cycles, %0d releases outstanding",
		         STALL_LIMIT, release_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		push   <= 1'b0;
		item   <= '0;
		arst_n <= 1'b0;
		gaps_on = 1;
		fail_count = 0;
		beats_sent = 0;
		ticks_sent = 0;
		releases_seen = 0;
		sched_count = 16'd0;
		for (int s = 0; s < TASK_COUNT; s++) begin
			sched_period[s] = 16'd0;
			sched_active[s] = 1'b1;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ticks();
		test_period_extremes();
		test_all_slots();
		test_suspend_resume();
		test_random(176);
		test_back_to_back();

		push <= 1'b0;
		while (release_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d command beats (%0d ticks), checked %0d release beats",
		         beats_sent, ticks_sent, releases_seen);
		$display("covered period extremes, suspend/resume, slot ordering and a gapless tail");
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ptrs_pkg.sv
rtl/ptrs_fifo.sv
rtl/ptrs_front.sv
rtl/ptrs_mod.sv
rtl/ptrs_back.sv
rtl/periodic_task_release_scheduler_top.sv
bench/periodic_task_release_scheduler_top_tb.sv
